### src/pabe_pkg.sv
// ============================================================================
// pabe_pkg: shared types and constants for the box extents block
// Field widths, register indexes and the transfer payload structs.
// ============================================================================
package pabe_pkg;

    localparam int COORD_W   = 24;                  // point and center width
    localparam int AXIS_FRAC = 16;                  // axis component fraction bits
    localparam int COMP_W    = AXIS_FRAC + 2;       // one axis component
    localparam int AXIS_W    = 3 * COMP_W;          // packed x,y,z components
    localparam int OUT_W     = 28;                  // bound width
    localparam int DIFF_W    = COORD_W + 1;         // point minus center
    localparam int PROD_W    = DIFF_W + COMP_W;     // one partial product
    localparam int SUM_W     = PROD_W + 2;          // sum of three products
    localparam int PROJ_W    = SUM_W - AXIS_FRAC;   // projection before clamp
    localparam int CFG_W     = AXIS_W;              // widest register
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X    = 3'd0,
        CFG_CENTER_Y    = 3'd1,
        CFG_CENTER_Z    = 3'd2,
        CFG_FIRST_AXIS  = 3'd3,
        CFG_SECOND_AXIS = 3'd4,
        CFG_THIRD_AXIS  = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      last_point;
    } in_item_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] first_low;
        logic signed [OUT_W-1:0] first_high;
        logic signed [OUT_W-1:0] second_low;
        logic signed [OUT_W-1:0] second_high;
        logic signed [OUT_W-1:0] third_low;
        logic signed [OUT_W-1:0] third_high;
    } out_item_t;

endpackage

### src/pabe_axis_proj.sv
// ============================================================================
// pabe_axis_proj: projection of a centered point onto one axis
// Three registered products, then a registered floor-shifted, clamped sum.
// ============================================================================
module pabe_axis_proj (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic signed [pabe_pkg::DIFF_W-1:0]     diff_x,
    input  logic signed [pabe_pkg::DIFF_W-1:0]     diff_y,
    input  logic signed [pabe_pkg::DIFF_W-1:0]     diff_z,
    input  logic        [pabe_pkg::AXIS_W-1:0]     axis,
    output logic signed [pabe_pkg::OUT_W-1:0]      proj
);

    logic signed [pabe_pkg::COMP_W-1:0] comp_x, comp_y, comp_z;
    logic signed [pabe_pkg::PROD_W-1:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [pabe_pkg::SUM_W-1:0]  sum;
    logic signed [pabe_pkg::PROJ_W-1:0] shifted;
    logic signed [pabe_pkg::OUT_W-1:0]  proj_next, proj_reg;

    // Unpack the axis components: x low, z high
    assign comp_x = $signed(axis[pabe_pkg::COMP_W-1:0]);
    assign comp_y = $signed(axis[2*pabe_pkg::COMP_W-1:pabe_pkg::COMP_W]);
    assign comp_z = $signed(axis[3*pabe_pkg::COMP_W-1:2*pabe_pkg::COMP_W]);

    // Register one product per component
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_x_reg <= pabe_pkg::PROD_W'(diff_x * comp_x);
            prod_y_reg <= pabe_pkg::PROD_W'(diff_y * comp_y);
            prod_z_reg <= pabe_pkg::PROD_W'(diff_z * comp_z);
        end
    end

    // Sum, drop the axis fraction bits (floor), clamp to the bound range
    always_comb begin
        sum = pabe_pkg::SUM_W'(prod_x_reg) + pabe_pkg::SUM_W'(prod_y_reg)
            + pabe_pkg::SUM_W'(prod_z_reg);
        shifted = sum[pabe_pkg::SUM_W-1:pabe_pkg::AXIS_FRAC];
        if (shifted > $signed(pabe_pkg::PROJ_W'({1'b0, {(pabe_pkg::OUT_W-1){1'b1}}}))) begin
            proj_next = {1'b0, {(pabe_pkg::OUT_W-1){1'b1}}};
        end else if (shifted < $signed(pabe_pkg::PROJ_W'(
                         {{(pabe_pkg::PROJ_W-pabe_pkg::OUT_W+1){1'b1}},
                          {(pabe_pkg::OUT_W-1){1'b0}}}))) begin
            proj_next = {1'b1, {(pabe_pkg::OUT_W-1){1'b0}}};
        end else begin
            proj_next = shifted[pabe_pkg::OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            proj_reg <= proj_next;
        end
    end

    assign proj = proj_reg;

endmodule

### src/principal_axis_box_extents.sv
// ============================================================================
// principal_axis_box_extents: box extents of a point set along three axes
// Running min/max of point projections onto three configured axes.
// ============================================================================
// Takes one point per cycle unless the bounds stage holds the pipeline. A
// point flagged last yields one result after passing the stages: register,
// subtract center, multiply, sum and shift, then fold into the bounds and load
// the output register. The bounds stage holds the pipeline only when a set's
// final point reaches it while the previous set's result is still waiting on
// m_ready; otherwise a point is taken every cycle. Write the center and axis
// registers only while the block is idle.
module principal_axis_box_extents (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [pabe_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pabe_pkg::CFG_W-1:0]            cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  pabe_pkg::in_item_t                    s_data,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output pabe_pkg::out_item_t                   m_data
);

    logic signed [pabe_pkg::COORD_W-1:0] center_x_reg, center_y_reg, center_z_reg;
    logic        [pabe_pkg::AXIS_W-1:0]  axis_reg [3];

    pabe_pkg::in_item_t                  in_reg;
    logic                                v1_reg, v2_reg, v3_reg, v4_reg;
    logic                                last2_reg, last3_reg, last4_reg;
    logic signed [pabe_pkg::DIFF_W-1:0]  diff_x_reg, diff_y_reg, diff_z_reg;
    logic signed [pabe_pkg::OUT_W-1:0]   proj [3];
    logic signed [pabe_pkg::OUT_W-1:0]   low_reg [3], low_next [3];
    logic signed [pabe_pkg::OUT_W-1:0]   high_reg [3], high_next [3];
    logic                                started_reg;
    logic                                adv, acc_fire;
    logic                                m_valid_reg;
    pabe_pkg::out_item_t                 m_data_reg;

    // Hold everything only when a result is blocked behind a waiting one
    assign adv      = !(v4_reg && last4_reg && m_valid_reg && !m_ready);
    assign s_ready  = adv;
    assign acc_fire = v4_reg && adv;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            axis_reg[0]  <= '0;
            axis_reg[1]  <= '0;
            axis_reg[2]  <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pabe_pkg::CFG_CENTER_X:    center_x_reg <= cfg_wdata[pabe_pkg::COORD_W-1:0];
                pabe_pkg::CFG_CENTER_Y:    center_y_reg <= cfg_wdata[pabe_pkg::COORD_W-1:0];
                pabe_pkg::CFG_CENTER_Z:    center_z_reg <= cfg_wdata[pabe_pkg::COORD_W-1:0];
                pabe_pkg::CFG_FIRST_AXIS:  axis_reg[0]  <= cfg_wdata[pabe_pkg::AXIS_W-1:0];
                pabe_pkg::CFG_SECOND_AXIS: axis_reg[1]  <= cfg_wdata[pabe_pkg::AXIS_W-1:0];
                pabe_pkg::CFG_THIRD_AXIS:  axis_reg[2]  <= cfg_wdata[pabe_pkg::AXIS_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the valid and last flags along the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Input register and centered point
    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg     <= s_data;
            last2_reg  <= in_reg.last_point;
            last3_reg  <= last2_reg;
            last4_reg  <= last3_reg;
            diff_x_reg <= pabe_pkg::DIFF_W'(in_reg.point_x) - pabe_pkg::DIFF_W'(center_x_reg);
            diff_y_reg <= pabe_pkg::DIFF_W'(in_reg.point_y) - pabe_pkg::DIFF_W'(center_y_reg);
            diff_z_reg <= pabe_pkg::DIFF_W'(in_reg.point_z) - pabe_pkg::DIFF_W'(center_z_reg);
        end
    end

    // One projection unit per axis
    for (genvar a = 0; a < 3; a++) begin : g_axis
        pabe_axis_proj u_proj (
            .aclk   (aclk),
            .en     (adv),
            .diff_x (diff_x_reg),
            .diff_y (diff_y_reg),
            .diff_z (diff_z_reg),
            .axis   (axis_reg[a]),
            .proj   (proj[a])
        );
    end

    // Fold the projection into the bounds; the first point of a set loads them
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            if (!started_reg) begin
                low_next[a]  = proj[a];
                high_next[a] = proj[a];
            end else begin
                low_next[a]  = (proj[a] < low_reg[a])  ? proj[a] : low_reg[a];
                high_next[a] = (proj[a] > high_reg[a]) ? proj[a] : high_reg[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                low_reg[a]  <= '0;
                high_reg[a] <= '0;
            end
        end else if (acc_fire) begin
            started_reg <= !last4_reg;
            for (int a = 0; a < 3; a++) begin
                low_reg[a]  <= low_next[a];
                high_reg[a] <= high_next[a];
            end
        end
    end

    // Output register: load on a final point, drop after the transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (acc_fire && last4_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_fire && last4_reg) begin
            m_data_reg.first_low   <= low_next[0];
            m_data_reg.first_high  <= high_next[0];
            m_data_reg.second_low  <= low_next[1];
            m_data_reg.second_high <= high_next[1];
            m_data_reg.third_low   <= low_next[2];
            m_data_reg.third_high  <= high_next[2];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A final point always leaves a result behind and ends the set
    a_last_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_fire && last4_reg) |=> (m_valid && !started_reg))
        else $error("final point did not load the output register");

    // Each delivered bound pair is ordered
    a_bounds_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.first_low <= m_data.first_high)
                 && (m_data.second_low <= m_data.second_high)
                 && (m_data.third_low <= m_data.third_high))
        else $error("result low bound above high bound");

    // Input is refused only while a result waits on the output side
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input held without a waiting result");

endmodule

### tb/sv/principal_axis_box_extents_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// principal_axis_box_extents_tb: self-checking bench for the box extents block
// Streams point sets through the block under several center and axis
// settings, recomputes the six bounds of every set in a scoreboard, and
// compares each result field by field. Sender bursts and receiver stalls vary.
// ============================================================================
module principal_axis_box_extents_tb;

    localparam int     CLK_HALF    = 10;
    localparam int     RESET_LEN   = 5;
    localparam int     PIPE_GUARD  = 10;        // cycles past the last result
    localparam int     CYCLE_LIMIT = 200000;
    localparam int     RAND_PHASES = 8;

    localparam longint BOUND_MAX = (longint'(1) <<< (pabe_pkg::OUT_W - 1)) - 1;
    localparam longint BOUND_MIN = -BOUND_MAX - 1;

    localparam logic [pabe_pkg::COORD_W-1:0] COORD_MAX =
        {1'b0, {(pabe_pkg::COORD_W-1){1'b1}}};
    localparam logic [pabe_pkg::COORD_W-1:0] COORD_MIN =
        {1'b1, {(pabe_pkg::COORD_W-1){1'b0}}};
    localparam logic [pabe_pkg::COMP_W-1:0]  COMP_MAX  =
        {1'b0, {(pabe_pkg::COMP_W-1){1'b1}}};
    localparam logic [pabe_pkg::COMP_W-1:0]  COMP_MIN  =
        {1'b1, {(pabe_pkg::COMP_W-1){1'b0}}};
    localparam logic [pabe_pkg::COMP_W-1:0]  COMP_ONE  =
        pabe_pkg::COMP_W'(1 << pabe_pkg::AXIS_FRAC);

    typedef enum int {MIX_RANDOM, MIX_HIGH, MIX_LOW} cfg_mix_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the register copy and running bounds, holds the
    // extents still owed by the block
    // ------------------------------------------------------------------------
    class extents_board;
        longint                      center_pos[3];
        logic [pabe_pkg::AXIS_W-1:0] axis_vec[3];
        longint                      bound_low[3];
        longint                      bound_high[3];
        bit                          set_open;
        pabe_pkg::out_item_t         extents_due[$];
        int                          mismatches;
        int                          results_seen;

        function void write_register(pabe_pkg::cfg_index_t idx,
                                     logic [pabe_pkg::CFG_W-1:0] v);
            case (idx)
                pabe_pkg::CFG_CENTER_X, pabe_pkg::CFG_CENTER_Y,
                pabe_pkg::CFG_CENTER_Z: begin
                    center_pos[int'(idx)] = longint'($signed(v[pabe_pkg::COORD_W-1:0]));
                end
                default: begin
                    axis_vec[int'(idx) - int'(pabe_pkg::CFG_FIRST_AXIS)] =
                        v[pabe_pkg::AXIS_W-1:0];
                end
            endcase
        endfunction

        // dot product, floor shift, clamp to the bound width
        function longint project_on(longint diff[3], logic [pabe_pkg::AXIS_W-1:0] axis);
            longint acc;
            longint comp;
            acc = 0;
            for (int c = 0; c < 3; c++) begin
                comp = $signed(axis[c*pabe_pkg::COMP_W +: pabe_pkg::COMP_W]);
                acc += diff[c] * comp;
            end
            acc = acc >>> pabe_pkg::AXIS_FRAC;
            if (acc > BOUND_MAX)
                acc = BOUND_MAX;
            else if (acc < BOUND_MIN)
                acc = BOUND_MIN;
            return acc;
        endfunction

        function void note_point(pabe_pkg::in_item_t pt);
            longint              diff[3];
            longint              proj;
            pabe_pkg::out_item_t due;
            diff[0] = longint'($signed(pt.point_x)) - center_pos[0];
            diff[1] = longint'($signed(pt.point_y)) - center_pos[1];
            diff[2] = longint'($signed(pt.point_z)) - center_pos[2];
            // fold the projections into the bounds; the first point loads them
            for (int a = 0; a < 3; a++) begin
                proj = project_on(diff, axis_vec[a]);
                if (!set_open) begin
                    bound_low[a]  = proj;
                    bound_high[a] = proj;
                end else begin
                    if (proj < bound_low[a])  bound_low[a]  = proj;
                    if (proj > bound_high[a]) bound_high[a] = proj;
                end
            end
            if (pt.last_point) begin
                due.first_low   = bound_low[0][pabe_pkg::OUT_W-1:0];
                due.first_high  = bound_high[0][pabe_pkg::OUT_W-1:0];
                due.second_low  = bound_low[1][pabe_pkg::OUT_W-1:0];
                due.second_high = bound_high[1][pabe_pkg::OUT_W-1:0];
                due.third_low   = bound_low[2][pabe_pkg::OUT_W-1:0];
                due.third_high  = bound_high[2][pabe_pkg::OUT_W-1:0];
                extents_due.push_back(due);
                set_open = 1'b0;
            end else begin
                set_open = 1'b1;
            end
        endfunction

        function void check_extents(pabe_pkg::out_item_t got);
            pabe_pkg::out_item_t              want;
            logic signed [pabe_pkg::OUT_W-1:0] w[6];
            logic signed [pabe_pkg::OUT_W-1:0] g[6];
            string                            label[6];
            results_seen++;
            if (extents_due.size() == 0) begin
                $display("%0t: result with nothing pending, actual %p", $time, got);
                mismatches++;
                return;
            end
            want  = extents_due.pop_front();
            w     = '{want.first_low, want.first_high, want.second_low,
                      want.second_high, want.third_low, want.third_high};
            g     = '{got.first_low, got.first_high, got.second_low,
                      got.second_high, got.third_low, got.third_high};
            label = '{"first_low", "first_high", "second_low",
                      "second_high", "third_low", "third_high"};
            for (int f = 0; f < 6; f++) begin
                if (g[f] !== w[f]) begin
                    $display("%0t: %s expected %0d actual %0d", $time, label[f], w[f], g[f]);
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return extents_due.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [pabe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [pabe_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    pabe_pkg::in_item_t             s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    pabe_pkg::out_item_t            m_data;

    extents_board board;
    int           points_taken  = 0;
    int           settings_used = 0;
    int           cycle_count   = 0;
    int           burst_left    = 0;
    int           ready_mode    = 0;

    principal_axis_box_extents DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: drive m_ready from one of four randomly chosen stall patterns
    always @(posedge aclk) begin
        if (cycle_count % 256 == 0)
            ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= ($urandom_range(0, 7) == 0);
            default: m_ready <= cycle_count[2] ^ cycle_count[4];
        endcase
    end

    // Monitor: check results before noting a point of the same edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                board.check_extents(m_data);
            if (s_valid && s_ready) begin
                board.note_point(s_data);
                points_taken++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic pabe_pkg::in_item_t make_point(logic [pabe_pkg::COORD_W-1:0] x,
                                                      logic [pabe_pkg::COORD_W-1:0] y,
                                                      logic [pabe_pkg::COORD_W-1:0] z,
                                                      logic last);
        pabe_pkg::in_item_t p;
        p.point_x    = x;
        p.point_y    = y;
        p.point_z    = z;
        p.last_point = last;
        return p;
    endfunction

    function automatic logic [pabe_pkg::AXIS_W-1:0] pack_axis(
        logic [pabe_pkg::COMP_W-1:0] cx,
        logic [pabe_pkg::COMP_W-1:0] cy,
        logic [pabe_pkg::COMP_W-1:0] cz);
        return {cz, cy, cx};
    endfunction

    function automatic logic [pabe_pkg::COORD_W-1:0] pick_coord();
        logic [pabe_pkg::COORD_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = COORD_MAX;
            1: v = COORD_MIN;
            2: v = '0;
            3, 4: begin
                v = pabe_pkg::COORD_W'($urandom_range(0, 4095));
                v = v - 2048;
            end
            default: v = pabe_pkg::COORD_W'($urandom());
        endcase
        return v;
    endfunction

    function automatic logic [pabe_pkg::COMP_W-1:0] pick_comp(cfg_mix_t mix);
        logic [pabe_pkg::COMP_W-1:0] v;
        if (mix == MIX_HIGH)
            return COMP_MAX;
        if (mix == MIX_LOW)
            return COMP_MIN;
        case ($urandom_range(0, 7))
            0: v = COMP_MAX;
            1: v = COMP_MIN;
            2: v = COMP_ONE;
            3: v = '0 - COMP_ONE;
            4: v = '0;
            default: v = pabe_pkg::COMP_W'($urandom());
        endcase
        return v;
    endfunction

    // Write all six registers, one per edge; block must be idle
    task automatic program_config(input logic [pabe_pkg::COORD_W-1:0] cx,
                                  input logic [pabe_pkg::COORD_W-1:0] cy,
                                  input logic [pabe_pkg::COORD_W-1:0] cz,
                                  input logic [pabe_pkg::AXIS_W-1:0]  a0,
                                  input logic [pabe_pkg::AXIS_W-1:0]  a1,
                                  input logic [pabe_pkg::AXIS_W-1:0]  a2);
        logic [pabe_pkg::CFG_W-1:0] vals[6];
        // random bits above the center field must be ignored
        for (int i = 0; i < 3; i++)
            vals[i] = pabe_pkg::CFG_W'({$urandom(), $urandom()});
        vals[int'(pabe_pkg::CFG_CENTER_X)][pabe_pkg::COORD_W-1:0] = cx;
        vals[int'(pabe_pkg::CFG_CENTER_Y)][pabe_pkg::COORD_W-1:0] = cy;
        vals[int'(pabe_pkg::CFG_CENTER_Z)][pabe_pkg::COORD_W-1:0] = cz;
        vals[int'(pabe_pkg::CFG_FIRST_AXIS)]  = a0;
        vals[int'(pabe_pkg::CFG_SECOND_AXIS)] = a1;
        vals[int'(pabe_pkg::CFG_THIRD_AXIS)]  = a2;
        for (int i = 0; i < 6; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= pabe_pkg::cfg_index_t'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
            board.write_register(pabe_pkg::cfg_index_t'(i), vals[i]);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic random_config(input cfg_mix_t mix);
        logic [pabe_pkg::COORD_W-1:0] c[3];
        logic [pabe_pkg::AXIS_W-1:0]  a[3];
        for (int i = 0; i < 3; i++) begin
            c[i] = (mix == MIX_HIGH) ? COORD_MIN : (mix == MIX_LOW) ? COORD_MAX : pick_coord();
            a[i] = pack_axis(pick_comp(mix), pick_comp(mix), pick_comp(mix));
        end
        program_config(c[0], c[1], c[2], a[0], a[1], a[2]);
    endtask

    // Hold the point until its transfer; open a random gap between bursts
    task automatic send_point(input pabe_pkg::in_item_t p);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        s_data  <= p;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Stop sending and wait until every owed result has arrived
    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (PIPE_GUARD) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int       n_items;
        int       last_odds;
        cfg_mix_t mix;

        board = new;
        repeat (RESET_LEN) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: zero axes, every bound is zero
        send_point(make_point(COORD_MAX, COORD_MIN, '0, 1'b0));
        send_point(make_point(pick_coord(), pick_coord(), pick_coord(), 1'b0));
        send_point(make_point(COORD_MIN, COORD_MAX, COORD_MAX, 1'b1));
        drain_pipeline();

        // unit axes: projections equal the coordinates
        program_config('0, '0, '0, pack_axis(COMP_ONE, '0, '0),
                       pack_axis('0, COMP_ONE, '0), pack_axis('0, '0, COMP_ONE));
        send_point(make_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
        send_point(make_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
        send_point(make_point(24'd100, -24'sd200, 24'd300, 1'b0));
        send_point(make_point(-24'sd5000, 24'd7000, '0, 1'b0));
        send_point(make_point('0, '0, -24'sd1, 1'b1));
        drain_pipeline();

        // leave a set open across a register change
        send_point(make_point(24'd256, 24'd512, -24'sd768, 1'b0));
        send_point(make_point(COORD_MAX, '0, COORD_MIN, 1'b0));
        drain_pipeline();
        program_config(COORD_MIN, COORD_MIN, COORD_MIN, pack_axis(COMP_MAX, COMP_MAX, COMP_MAX),
                       pack_axis(COMP_MAX, COMP_MIN, COMP_ONE),
                       pack_axis(COMP_MIN, COMP_MIN, COMP_MIN));
        send_point(make_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
        send_point(make_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1));
        drain_pipeline();

        // opposite extremes: largest differences times most negative and most positive components
        program_config(COORD_MAX, COORD_MAX, COORD_MAX, pack_axis(COMP_MIN, COMP_MIN, COMP_MIN),
                       pack_axis(COMP_MAX, COMP_MAX, COMP_MAX),
                       pack_axis(COMP_MIN, COMP_MAX, '0));
        send_point(make_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));
        send_point(make_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1));
        drain_pipeline();

        // random phases, each under its own settings
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            mix = (ph == 2) ? MIX_HIGH : (ph == 5) ? MIX_LOW : MIX_RANDOM;
            random_config(mix);
            n_items   = $urandom_range(50, 75);
            last_odds = (ph == 4) ? 1 : $urandom_range(2, 12);
            for (int i = 0; i < n_items; i++)
                send_point(make_point(pick_coord(), pick_coord(), pick_coord(),
                                      $urandom_range(1, last_odds) == 1));
            // close most sets; some stay open into the next settings
            if ($urandom_range(0, 2) != 0)
                send_point(make_point(pick_coord(), pick_coord(), pick_coord(), 1'b1));
            drain_pipeline();
        end

        $display("Covered %0d points and %0d extents results over %0d register settings,",
                 points_taken, board.results_seen, settings_used);
        $display("with sender bursts and gaps and four receiver stall patterns.");
        if (board.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
